// File: hw/rtl/mvla_pkg.sv
// ----------------------------------------------------------------------------
// mvla_pkg
// shared types, codes and defaults for the manhattan voronoi area block
// ----------------------------------------------------------------------------
`default_nettype none

package mvla_pkg;

    // default sizes
    localparam int MAX_SEEDS_DEF = 64;
    localparam int MAX_GRID_DEF  = 1024;

    // fixed field widths
    localparam int SEED_W   = 10;
    localparam int CFG_W    = 11;
    localparam int AREA_W   = 21;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0]  GRID_RST = CFG_W'(512);
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STS_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_OUTSIDE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd3;

    typedef struct packed {
        logic              func;
        logic [SEED_W-1:0] seed_x;
        logic [SEED_W-1:0] seed_y;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AREA_W-1:0]   peak_area;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_ADV,
        ST_FIND,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/mvla_ram.sv
// ----------------------------------------------------------------------------
// mvla_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mvla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/manhattan_voronoi_largest_finite_area.sv
// ----------------------------------------------------------------------------
// manhattan_voronoi_largest_finite_area
// labels a square grid by nearest seed (manhattan distance) and reports the
// largest region that does not touch the grid border
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                payload
//  -------   ---------  -----------------------  ----------------------------
//  in        sink       i_in_valid / o_in_stall  t_in_item  (func, seed x, y)
//  out       source     o_out_valid / i_out_stall t_out_item (status, area)
//  cfg       sink       i_cfg_we                 grid size, 11 bits
//
//  a seed load is answered from the output register
//  in a run every cell reads the seed ram once per seed, then does a
//  read-modify-write of the area ram unless it is tied between seeds;
//  a final sweep of the area ram picks the largest finite one, and a run
//  with no seeds goes straight to its result
//  synchronous active-low reset clears the seed count, state and output valid
//  input is stalled while a run is in progress or the result cannot be placed
// ----------------------------------------------------------------------------
`default_nettype none

module manhattan_voronoi_largest_finite_area #(
    parameter int MAX_SEEDS = mvla_pkg::MAX_SEEDS_DEF,
    parameter int MAX_GRID  = mvla_pkg::MAX_GRID_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input transactions
    input  wire                        i_in_valid,
    input  wire  mvla_pkg::t_in_item   i_in_data,
    output logic                       o_in_stall,
    // result transactions
    output logic                       o_out_valid,
    output mvla_pkg::t_out_item        o_out_data,
    input  wire                        i_out_stall,
    // configuration
    input  wire                        i_cfg_we,
    input  wire  [mvla_pkg::CFG_W-1:0] i_cfg_data
);

    import mvla_pkg::*;

    // seed index, seed count, grid coordinate and distance widths
    localparam int SW  = $clog2(MAX_SEEDS);
    localparam int SCW = $clog2(MAX_SEEDS + 1);
    localparam int CW  = $clog2(MAX_GRID);
    localparam int XW  = (CW > SEED_W) ? CW : SEED_W;
    localparam int DW  = XW + 1;
    localparam int GW  = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
    localparam int AW1 = AREA_W + 1;

    localparam logic [GW-1:0]  GRID_MIN = GW'(2);
    localparam logic [GW-1:0]  GRID_TOP = GW'(MAX_GRID);
    localparam logic [SCW-1:0] CNT_FULL = SCW'(MAX_SEEDS);

    // control state
    t_state          r_state, n_state;
    logic [CFG_W-1:0] r_grid;
    logic [SCW-1:0]  r_cnt, n_cnt;
    logic [SCW-1:0]  r_sidx, n_sidx;
    logic            r_pv, n_pv;
    logic [MAX_SEEDS-1:0] r_av, n_av;
    logic            r_out_vld, n_out_vld;

    // datapath state
    logic [SW-1:0]   r_pidx, n_pidx;
    logic [CW-1:0]   r_x, n_x;
    logic [CW-1:0]   r_y, n_y;
    logic [CW-1:0]   r_nm1, n_nm1;
    logic [DW-1:0]   r_min, n_min;
    logic [SW-1:0]   r_owner, n_owner;
    logic            r_tie, n_tie;
    logic            r_rv, n_rv;
    logic [AREA_W-1:0] r_best, n_best;
    t_out_item       r_out, n_out;

    // ram ports
    logic                  seed_we;
    logic [SW-1:0]         seed_waddr;
    logic [2*SEED_W-1:0]   seed_wdata;
    logic [2*SEED_W-1:0]   seed_rdata;
    logic                  area_we;
    logic [AW1-1:0]        area_wdata;
    logic [SW-1:0]         area_raddr;
    logic [AW1-1:0]        area_rdata;

    // handshakes
    logic in_acc;
    logic out_free;

    // effective grid size, clamped to the legal range
    logic [GW-1:0]  grid_ext;
    logic [GW-1:0]  grid_eff;
    logic [GW-1:0]  grid_m1;

    // per-seed distance
    logic [XW-1:0]  sx, sy, cx, cy, dx, dy;
    logic [DW-1:0]  seed_dist;
    logic [SCW-1:0] cnt_m1;
    logic           issue;
    logic           last_rd;
    logic           on_edge;
    logic           last_cell;
    logic [AREA_W-1:0] cur_area;
    logic              cur_border;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        grid_ext = GW'(r_grid);
        if (grid_ext < GRID_MIN) begin
            grid_eff = GRID_MIN;
        end else if (grid_ext > GRID_TOP) begin
            grid_eff = GRID_TOP;
        end else begin
            grid_eff = grid_ext;
        end
        grid_m1 = grid_eff - GW'(1);
    end

    // distance from the current cell to the seed just read
    always_comb begin
        sx   = XW'(seed_rdata[SEED_W-1:0]);
        sy   = XW'(seed_rdata[2*SEED_W-1:SEED_W]);
        cx   = XW'(r_x);
        cy   = XW'(r_y);
        dx   = (cx > sx) ? (cx - sx) : (sx - cx);
        dy   = (cy > sy) ? (cy - sy) : (sy - cy);
        seed_dist = DW'(dx) + DW'(dy);
    end

    assign cnt_m1     = r_cnt - SCW'(1);
    assign issue      = (r_sidx != r_cnt);
    assign last_rd    = r_pv && (r_pidx == cnt_m1[SW-1:0]);
    assign on_edge    = (r_x == '0) || (r_y == '0) || (r_x == r_nm1) || (r_y == r_nm1);
    assign last_cell  = (r_x == r_nm1) && (r_y == r_nm1);
    assign cur_area   = r_rv ? area_rdata[AREA_W-1:0] : '0;
    assign cur_border = r_rv ? area_rdata[AREA_W] : 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.func == FUNC_RUN)) begin
                    n_state = (r_cnt == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_rd) begin
                    n_state = ST_UPD_RD;
                end
            end
            ST_UPD_RD: begin
                n_state = r_tie ? ST_ADV : ST_UPD_WR;
            end
            ST_UPD_WR: begin
                n_state = ST_ADV;
            end
            ST_ADV: begin
                n_state = last_cell ? ST_FIND : ST_SCAN;
            end
            ST_FIND: begin
                if (last_rd) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_cnt     = r_cnt;
        n_sidx    = r_sidx;
        n_pv      = 1'b0;
        n_pidx    = r_sidx[SW-1:0];
        n_av      = r_av;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        n_x       = r_x;
        n_y       = r_y;
        n_nm1     = r_nm1;
        n_min     = r_min;
        n_owner   = r_owner;
        n_tie     = r_tie;
        n_rv      = r_rv;
        n_best    = r_best;

        seed_we    = 1'b0;
        seed_waddr = r_cnt[SW-1:0];
        seed_wdata = {i_in_data.seed_y, i_in_data.seed_x};
        area_we    = 1'b0;
        area_wdata = {cur_border | on_edge,
                      (cur_area == AREA_MAX) ? cur_area : cur_area + AREA_W'(1)};
        area_raddr = (r_state == ST_UPD_RD) ? r_owner : r_sidx[SW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                n_sidx = '0;
                if (in_acc) begin
                    if (i_in_data.func == FUNC_RUN) begin
                        // fresh run: every area entry reads as zero
                        n_av   = '0;
                        n_x    = '0;
                        n_y    = '0;
                        n_nm1  = grid_m1[CW-1:0];
                        n_best = '0;
                    end else begin
                        n_out_vld       = 1'b1;
                        n_out.peak_area = '0;
                        if (r_cnt == CNT_FULL) begin
                            n_out.status = STS_FULL;
                        end else if ((GW'(i_in_data.seed_x) >= grid_eff) ||
                                     (GW'(i_in_data.seed_y) >= grid_eff)) begin
                            n_out.status = STS_OUTSIDE;
                        end else begin
                            n_out.status = STS_STORED;
                            seed_we      = 1'b1;
                            n_cnt        = r_cnt + SCW'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_pv   = 1'b1;
                    n_sidx = r_sidx + SCW'(1);
                end
                if (r_pv) begin
                    if ((r_pidx == '0) || (seed_dist < r_min)) begin
                        n_min   = seed_dist;
                        n_owner = r_pidx;
                        n_tie   = 1'b0;
                    end else if (seed_dist == r_min) begin
                        n_tie = 1'b1;
                    end
                end
            end
            ST_UPD_RD: begin
                n_rv = r_av[r_owner];
            end
            ST_UPD_WR: begin
                area_we        = 1'b1;
                n_av[r_owner]  = 1'b1;
            end
            ST_ADV: begin
                n_sidx = '0;
                if (r_x == r_nm1) begin
                    n_x = '0;
                    n_y = r_y + CW'(1);
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            ST_FIND: begin
                if (issue) begin
                    n_pv   = 1'b1;
                    n_sidx = r_sidx + SCW'(1);
                    n_rv   = r_av[r_sidx[SW-1:0]];
                end
                if (r_pv && !cur_border && (cur_area > r_best)) begin
                    n_best = cur_area;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld       = 1'b1;
                    n_out.status    = STS_DONE;
                    n_out.peak_area = r_best;
                    n_cnt           = '0;
                end
            end
            default: begin
                n_sidx = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_grid    <= GRID_RST;
            r_cnt     <= '0;
            r_sidx    <= '0;
            r_pv      <= 1'b0;
            r_av      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sidx    <= n_sidx;
            r_pv      <= n_pv;
            r_av      <= n_av;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_grid <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_x     <= n_x;
        r_y     <= n_y;
        r_nm1   <= n_nm1;
        r_min   <= n_min;
        r_owner <= n_owner;
        r_tie   <= n_tie;
        r_rv    <= n_rv;
        r_best  <= n_best;
        r_out   <= n_out;
    end

    // seed store: row in the upper half, column in the lower half
    mvla_ram #(
        .WIDTH (2 * SEED_W),
        .DEPTH (MAX_SEEDS)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (seed_we),
        .i_waddr (seed_waddr),
        .i_wdata (seed_wdata),
        .i_raddr (r_sidx[SW-1:0]),
        .o_rdata (seed_rdata)
    );

    // per-seed area count with the border flag on top
    mvla_ram #(
        .WIDTH (AW1),
        .DEPTH (MAX_SEEDS)
    ) u_area_ram (
        .i_clk   (i_clk),
        .i_we    (area_we),
        .i_waddr (r_owner),
        .i_wdata (area_wdata),
        .i_raddr (area_raddr),
        .o_rdata (area_rdata)
    );

endmodule

`default_nettype wire
